>>> rtl/eccpr_pkg.sv
// Shared constants and types for the enhanced clock page replacer.
`timescale 1ns / 1ps

package eccpr_pkg;

   // Frame table geometry
   localparam int NUM_FRAMES = 4;
   localparam int PAGE_BITS  = 20;
   localparam int FRAME_W    = $clog2(NUM_FRAMES);

   // Result frame index field width
   localparam int IDX_W      = 2;

   // Sweep rounds: A (clean), B (dirty, clears use), A, B
   localparam int NUM_ROUNDS = 4;
   localparam int ROUND_W    = 2;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // One reference word
   typedef struct packed {
      logic [PAGE_BITS-1:0] page_number;
      logic                 is_write;
   } req_word_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } queue_head_type;

endpackage

>>> rtl/enhanced_clock_page_replacer.sv
// Enhanced second-chance clock page replacer, top level.
`timescale 1ns / 1ps

// Takes one page reference per word (page number, write flag) and returns one
// result word: hit or miss, the frame now holding the page, and on a miss the
// evicted page and its dirty flag. Incoming words wait in a two-entry queue, so
// the sender is stalled only when that queue is full; results sit in an output
// register, and the next reference is worked on while a result waits. A hit is
// finished in the tag check once the result slot is free. A miss passes through
// the tag check, then the sweep, where the clock hand visits a single frame per
// cycle over up to four rounds, then the load of the victim into its frame.
module enhanced_clock_page_replacer
   import eccpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PAGE_BITS-1:0] req_page_number,
   input  logic                 req_is_write,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [IDX_W-1:0]     rsp_frame_index,
   output logic                 rsp_evicted_valid,
   output logic [PAGE_BITS-1:0] rsp_evicted_page,
   output logic                 rsp_evicted_dirty
);

   queue_head_type head;
   logic           pop;

   // Accept and queue references
   eccpr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_number (req_page_number),
      .req_is_write    (req_is_write),
      .head            (head),
      .pop             (pop)
   );

   // Look up, sweep and report
   eccpr_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_evicted_dirty (rsp_evicted_dirty)
   );

endmodule

>>> rtl/eccpr_front.sv
// Front end: accepts reference words and holds them in a short queue.
`timescale 1ns / 1ps

module eccpr_front
   import eccpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PAGE_BITS-1:0] req_page_number,
   input  logic                 req_is_write,
   output queue_head_type       head,
   input  logic                 pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_word_type     queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   req_word_type     push_word;

   // Full queue stalls the sender
   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   assign push_word.page_number = req_page_number;
   assign push_word.is_write    = req_is_write;

   // Head word for the back end
   assign head.valid = (count_ff != '0);
   assign head.word  = queue_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> rtl/eccpr_engine.sv
// Back end: hit check, clock sweep, frame table and result register.
`timescale 1ns / 1ps

module eccpr_engine
   import eccpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  queue_head_type       head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [IDX_W-1:0]     rsp_frame_index,
   output logic                 rsp_evicted_valid,
   output logic [PAGE_BITS-1:0] rsp_evicted_page,
   output logic                 rsp_evicted_dirty
);

   localparam logic [1:0] ST_CHECK = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

   // Frame table
   logic [PAGE_BITS-1:0]  tag_ff [NUM_FRAMES];
   logic [PAGE_BITS-1:0]  tag_in [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [NUM_FRAMES-1:0] use_ff, use_in;
   logic [NUM_FRAMES-1:0] dirty_ff, dirty_in;
   logic [FRAME_W-1:0]    hand_ff, hand_in;

   // Sequencer
   logic [1:0]            state_ff, state_in;
   logic [ROUND_W-1:0]    round_ff, round_in;
   logic [FRAME_W-1:0]    step_ff, step_in;
   logic [PAGE_BITS-1:0]  cur_page_ff, cur_page_in;
   logic                  cur_wr_ff, cur_wr_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]      rsp_frame_ff, rsp_frame_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_BITS-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic                  rsp_ev_dirty_ff, rsp_ev_dirty_in;

   logic                  hit_any;
   logic [FRAME_W-1:0]    hit_idx;
   logic                  out_free;
   logic [FRAME_W-1:0]    hand_next;

   function automatic logic [FRAME_W-1:0] advance(input logic [FRAME_W-1:0] h);
      return (h == LAST_FRAME) ? '0 : FRAME_W'(h + 1'b1);
   endfunction

   assign hand_next = advance(hand_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Tag match over valid frames, lowest index wins
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == head.word.page_number)) begin
            hit_any = 1'b1;
            hit_idx = FRAME_W'(i);
         end
      end
   end

   // Next-state logic
   always_comb begin
      tag_in          = tag_ff;
      valid_in        = valid_ff;
      use_in          = use_ff;
      dirty_in        = dirty_ff;
      hand_in         = hand_ff;
      state_in        = state_ff;
      round_in        = round_ff;
      step_in         = step_ff;
      cur_page_in     = cur_page_ff;
      cur_wr_in       = cur_wr_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_ev_dirty_in = rsp_ev_dirty_ff;
      pop             = 1'b0;

      // Result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CHECK: begin
            if (head.valid) begin
               if (hit_any) begin
                  // Hit: finish in this cycle once the result slot is free
                  if (out_free) begin
                     pop               = 1'b1;
                     use_in[hit_idx]   = 1'b1;
                     if (head.word.is_write) begin
                        dirty_in[hit_idx] = 1'b1;
                     end
                     rsp_valid_in    = 1'b1;
                     rsp_hit_in      = 1'b1;
                     rsp_frame_in    = IDX_W'(hit_idx);
                     rsp_ev_valid_in = 1'b0;
                     rsp_ev_page_in  = '0;
                     rsp_ev_dirty_in = 1'b0;
                  end
               end else begin
                  // Miss: take the word and start sweeping
                  pop         = 1'b1;
                  cur_page_in = head.word.page_number;
                  cur_wr_in   = head.word.is_write;
                  round_in    = '0;
                  step_in     = '0;
                  state_in    = ST_SWEEP;
               end
            end
         end

         ST_SWEEP: begin
            // One frame per cycle; odd rounds look for dirty and clear use
            if (!use_ff[hand_ff] && (dirty_ff[hand_ff] == round_ff[0])) begin
               state_in = ST_DONE;
            end else begin
               if (round_ff[0]) begin
                  use_in[hand_ff] = 1'b0;
               end
               hand_in = hand_next;
               if (step_ff == LAST_FRAME) begin
                  step_in  = '0;
                  round_in = ROUND_W'(round_ff + 1'b1);
                  // Guard: no victim in all rounds, take the frame under the hand
                  if (round_ff == LAST_ROUND) begin
                     state_in = ST_DONE;
                  end
               end else begin
                  step_in = FRAME_W'(step_ff + 1'b1);
               end
            end
         end

         ST_DONE: begin
            // Victim is the frame under the hand
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = 1'b0;
               rsp_frame_in    = IDX_W'(hand_ff);
               rsp_ev_valid_in = valid_ff[hand_ff];
               rsp_ev_page_in  = valid_ff[hand_ff] ? tag_ff[hand_ff] : '0;
               rsp_ev_dirty_in = valid_ff[hand_ff] && dirty_ff[hand_ff];
               tag_in[hand_ff]   = cur_page_ff;
               valid_in[hand_ff] = 1'b1;
               use_in[hand_ff]   = 1'b1;
               dirty_in[hand_ff] = cur_wr_ff;
               hand_in           = hand_next;
               state_in          = ST_CHECK;
            end
         end

         default: begin
            state_in = ST_CHECK;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         use_ff       <= '0;
         dirty_ff     <= '0;
         hand_ff      <= '0;
         state_ff     <= ST_CHECK;
         round_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         use_ff       <= use_in;
         dirty_ff     <= dirty_in;
         hand_ff      <= hand_in;
         state_ff     <= state_in;
         round_ff     <= round_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      tag_ff          <= tag_in;
      cur_page_ff     <= cur_page_in;
      cur_wr_ff       <= cur_wr_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_ev_dirty_ff <= rsp_ev_dirty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_evicted_dirty = rsp_ev_dirty_ff;

endmodule

>>> tb/sv/tb_enhanced_clock_page_replacer.sv
// Self-checking testbench for the enhanced clock page replacer.
`timescale 1ns / 1ps

module tb_enhanced_clock_page_replacer;
   import eccpr_pkg::*;

   // Access kinds carried in the write flag
   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;

   localparam int RANDOM_REFS  = 2000;
   localparam int HOLD_AT      = 400;   // result count that starts the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   // Expected result word
   typedef struct packed {
      logic                 hit;
      logic [IDX_W-1:0]     frame;
      logic                 ev_valid;
      logic [PAGE_BITS-1:0] ev_page;
      logic                 ev_dirty;
   } outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PAGE_BITS-1:0] req_page_number = '0;
   logic                 req_is_write = ACCESS_READ;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_hit;
   logic [IDX_W-1:0]     rsp_frame_index;
   logic                 rsp_evicted_valid;
   logic [PAGE_BITS-1:0] rsp_evicted_page;
   logic                 rsp_evicted_dirty;

   req_word_type pending_refs[$];
   outcome_type  expected_outcomes[$];
   int           total_refs;
   int           accepted_count = 0;
   int           sent_count = 0;
   int           results_seen = 0;
   int           error_count = 0;
   int           send_gap = 0;
   int           recv_wait = 0;
   int           hold_left = 0;
   bit           hold_done = 0;

   // Shadow frame table
   logic [PAGE_BITS-1:0] tag_mem [NUM_FRAMES];
   bit                   resident [NUM_FRAMES];
   bit                   referenced [NUM_FRAMES];
   bit                   modified [NUM_FRAMES];
   int                   sweep_ptr;

   enhanced_clock_page_replacer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .req_is_write      (req_is_write),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_evicted_dirty (rsp_evicted_dirty)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one reference to the shadow table and returns the result word it causes
   function automatic outcome_type predict_reference(input logic [PAGE_BITS-1:0] page,
                                                     input logic wr);
      outcome_type res;
      int          slot;
      int          victim;
      bit          found;
      bit          want_modified;
      res = '0;
      slot = -1;
      // lowest matching valid frame wins
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (slot < 0 && resident[i] && tag_mem[i] == page) slot = i;
      end
      if (slot >= 0) begin
         referenced[slot] = 1;
         if (wr == ACCESS_WRITE) modified[slot] = 1;
         res.hit   = 1'b1;
         res.frame = slot[IDX_W-1:0];
         return res;
      end
      // miss: clean-unused rounds alternate with dirty-unused rounds that clear use bits
      victim = sweep_ptr;
      found  = 0;
      for (int r = 0; r < NUM_ROUNDS && !found; r++) begin
         want_modified = (r % 2) == 1;
         for (int k = 0; k < NUM_FRAMES && !found; k++) begin
            if (!referenced[sweep_ptr] && modified[sweep_ptr] == want_modified) begin
               victim = sweep_ptr;
               found  = 1;
            end else begin
               if (want_modified) referenced[sweep_ptr] = 0;
               sweep_ptr = (sweep_ptr + 1) % NUM_FRAMES;
            end
         end
      end
      if (!found) victim = sweep_ptr;
      res.frame = victim[IDX_W-1:0];
      if (resident[victim]) begin
         res.ev_valid = 1'b1;
         res.ev_page  = tag_mem[victim];
         res.ev_dirty = modified[victim];
      end
      tag_mem[victim]    = page;
      resident[victim]   = 1;
      referenced[victim] = 1;
      modified[victim]   = wr;
      sweep_ptr          = (victim + 1) % NUM_FRAMES;
      return res;
   endfunction

   task automatic add_ref(input logic [PAGE_BITS-1:0] page, input logic wr);
      req_word_type w;
      w.page_number = page;
      w.is_write    = wr;
      pending_refs.push_back(w);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Sender: presents queued words, with drawn idle gaps while sent_count[6] is 0
   always @(posedge clock) begin : ref_driver
      req_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            resident[i]   = 0;
            referenced[i] = 0;
            modified[i]   = 0;
         end
         sweep_ptr = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(predict_reference(req_page_number, req_is_write));
            accepted_count++;
         end
         // a stalled word stays put
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_refs.size() != 0) begin
               nxt = pending_refs.pop_front();
               req_valid       <= 1'b1;
               req_page_number <= nxt.page_number;
               req_is_write    <= nxt.is_write;
               send_gap = sent_count[6] ? 0 : $urandom_range(0, 15);
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result word, with drawn stalls while results_seen[5] is 0
   always @(posedge clock) begin : result_check
      outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result word: hit %0b frame %0d", $time,
                        rsp_hit, rsp_frame_index);
               error_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("frame_index", 32'(want.frame), 32'(rsp_frame_index));
               check_field("evicted_valid", 32'(want.ev_valid), 32'(rsp_evicted_valid));
               check_field("evicted_page", 32'(want.ev_page), 32'(rsp_evicted_page));
               check_field("evicted_dirty", 32'(want.ev_dirty), 32'(rsp_evicted_dirty));
            end
            results_seen++;
            recv_wait = results_seen[5] ? 0 : $urandom_range(0, 15);
            // one long hold-off so the input queue fills and backs up
            if (results_seen == HOLD_AT && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [PAGE_BITS-1:0] hot_pages [8];
      int                   hot_count;
      int                   write_pct;
      int                   pick;
      int                   slot;
      logic [PAGE_BITS-1:0] page;

      // fill empty frames, with field extremes
      add_ref(20'h00000, ACCESS_READ);
      add_ref(20'hFFFFF, ACCESS_WRITE);
      add_ref(20'h00000, ACCESS_WRITE);   // write hit marks frame dirty
      add_ref(20'h55555, ACCESS_READ);
      add_ref(20'hAAAAA, ACCESS_WRITE);
      add_ref(20'hFFFFF, ACCESS_READ);    // read hit
      // all frames used: sweep clears use bits, takes the clean frame
      add_ref(20'h12345, ACCESS_READ);
      // no clean unused frame left: dirty victim
      add_ref(20'h12346, ACCESS_READ);
      // make every frame used and dirty, then miss: full four-round sweep
      add_ref(20'h00000, ACCESS_WRITE);
      add_ref(20'hFFFFF, ACCESS_WRITE);
      add_ref(20'h12345, ACCESS_WRITE);
      add_ref(20'h12346, ACCESS_WRITE);
      add_ref(20'h00001, ACCESS_READ);
      // bring back evicted pages, page differing from a resident one by one bit
      add_ref(20'h55555, ACCESS_WRITE);
      add_ref(20'hAAAAA, ACCESS_READ);
      add_ref(20'h00001, ACCESS_WRITE);
      add_ref(20'h80000, ACCESS_READ);
      add_ref(20'h7FFFF, ACCESS_WRITE);
      add_ref(20'h80000, ACCESS_READ);

      // random part: references mostly from a small working set, so hits,
      // clean and dirty evictions all show up; some pages over the full range
      hot_count = 6;
      write_pct = 50;
      for (int i = 0; i < 8; i++) hot_pages[i] = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
      for (int n = 0; n < RANDOM_REFS; n++) begin
         if (n % 250 == 0) begin
            hot_count = $urandom_range(3, 8);
            write_pct = $urandom_range(0, 100);
         end
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, hot_count - 1);
         if (pick < 75) begin
            page = hot_pages[slot];
         end else if (pick < 85) begin
            hot_pages[slot] = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
            page = hot_pages[slot];
         end else begin
            page = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
         end
         add_ref(page, ($urandom_range(0, 99) < write_pct) ? ACCESS_WRITE : ACCESS_READ);
      end
      total_refs = pending_refs.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_refs || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, expected_outcomes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
